@@ rtl/lpi_pkg.sv @@
// Shared types and constants for the line/plane intersection pipeline.
package lpi_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CW         = COORD_BITS;
    localparam int DOTW       = 2 * CW + 2;
    localparam int NUMW       = 2 * CW + 3;
    localparam int NW         = NUMW + FRAC_BITS;
    localparam int QB         = CW + FRAC_BITS + 2;
    localparam int TW         = QB + 1;
    localparam int LOB        = TW / 2;
    localparam int HIB        = TW - LOB;
    localparam int PPW        = CW + HIB + 1;
    localparam int PRODW      = CW + TW;
    localparam int RW         = PRODW - FRAC_BITS + 1;
    localparam int THRW       = 16;
    localparam int AW         = 3;
    localparam int DW         = 32;

    localparam logic [QB-1:0] TLIM = {1'b1, {(QB-1){1'b0}}};

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic [THRW-1:0] THRESHOLD_RESET = THRW'(1);

    typedef logic [2:0][CW-1:0] vec_t;

    typedef struct packed {
        vec_t p;
        vec_t v;
    } line_t;

    typedef struct packed {
        logic            vld;
        logic            para;
        logic            neg;
        logic            ovf;
        logic [DOTW-1:0] mag;
        logic [DOTW-1:0] rem;
        logic [NW-1:0]   num;
        logic [QB-1:0]   quo;
        line_t           ln;
    } div_t;

endpackage

@@ rtl/lpi_req_if.sv @@
// Request channel: one plane and one line per request.
interface lpi_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] plane_normal_x;
    logic [31:0] plane_normal_y;
    logic [31:0] plane_normal_z;
    logic [31:0] plane_offset;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] dir_z;

    modport source (
        output valid, plane_normal_x, plane_normal_y, plane_normal_z, plane_offset,
        output point_x, point_y, point_z, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, plane_normal_x, plane_normal_y, plane_normal_z, plane_offset,
        input  point_x, point_y, point_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

@@ rtl/lpi_rsp_if.sv @@
// Response channel: hit flag, intersection point and saturation flag.
interface lpi_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] hit_x;
    logic [31:0] hit_y;
    logic [31:0] hit_z;
    logic        saturated;

    modport source (
        output valid, hit, hit_x, hit_y, hit_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_x, hit_y, hit_z, saturated,
        output ready
    );
endinterface

@@ rtl/lpi_dot.sv @@
// Dot products, sums and divider setup: three pipeline stages.
module lpi_dot (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_vld,
    input  lpi_pkg::vec_t             n,
    input  logic [lpi_pkg::CW-1:0]    d,
    input  lpi_pkg::line_t            ln,
    input  logic [lpi_pkg::THRW-1:0]  thr,
    output lpi_pkg::div_t             setup
);

    logic                                s1_vld_reg;
    logic signed [2*lpi_pkg::CW-1:0]     pnv_reg [3];
    logic signed [2*lpi_pkg::CW-1:0]     pnp_reg [3];
    logic signed [2*lpi_pkg::CW-1:0]     pnv_next [3];
    logic signed [2*lpi_pkg::CW-1:0]     pnp_next [3];
    logic [lpi_pkg::CW-1:0]              d1_reg;
    lpi_pkg::line_t                      ln1_reg;

    logic                                s2_vld_reg;
    logic signed [lpi_pkg::DOTW-1:0]     dot_reg;
    logic signed [lpi_pkg::NUMW-1:0]     num_reg;
    logic signed [lpi_pkg::DOTW-1:0]     dot_next;
    logic signed [lpi_pkg::NUMW-1:0]     num_next;
    lpi_pkg::line_t                      ln2_reg;

    lpi_pkg::div_t                       setup_reg;
    lpi_pkg::div_t                       setup_next;
    logic [lpi_pkg::DOTW-1:0]            mag;
    logic [lpi_pkg::NUMW-1:0]            num_abs;
    logic [lpi_pkg::NW-1:0]              num_sh;
    logic                                num_pos;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pnv_next[i] = $signed(n[i]) * $signed(ln.v[i]);
            pnp_next[i] = $signed(n[i]) * $signed(ln.p[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pnv_reg <= pnv_next;
            pnp_reg <= pnp_next;
            d1_reg  <= d;
            ln1_reg <= ln;
        end
    end

    always_comb
    begin
        dot_next = lpi_pkg::DOTW'(pnv_reg[0]) + lpi_pkg::DOTW'(pnv_reg[1])
                 + lpi_pkg::DOTW'(pnv_reg[2]);
        num_next = lpi_pkg::NUMW'(pnp_reg[0]) + lpi_pkg::NUMW'(pnp_reg[1])
                 + lpi_pkg::NUMW'(pnp_reg[2])
                 + (lpi_pkg::NUMW'($signed(d1_reg)) <<< lpi_pkg::FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg <= dot_next;
            num_reg <= num_next;
            ln2_reg <= ln1_reg;
        end
    end

    always_comb
    begin
        mag     = dot_reg[lpi_pkg::DOTW-1] ? lpi_pkg::DOTW'(-dot_reg)
                                           : lpi_pkg::DOTW'(dot_reg);
        num_abs = num_reg[lpi_pkg::NUMW-1] ? lpi_pkg::NUMW'(-num_reg)
                                           : lpi_pkg::NUMW'(num_reg);
        num_sh  = {num_abs, {lpi_pkg::FRAC_BITS{1'b0}}};
        num_pos = !num_reg[lpi_pkg::NUMW-1] && (num_reg != '0);

        setup_next.vld  = s2_vld_reg;
        setup_next.para = (mag == '0)
                       || (mag < (lpi_pkg::DOTW'(thr) << lpi_pkg::FRAC_BITS));
        setup_next.neg  = num_pos ^ dot_reg[lpi_pkg::DOTW-1];
        setup_next.ovf  = lpi_pkg::DOTW'(num_sh[lpi_pkg::NW-1:lpi_pkg::QB]) >= mag;
        setup_next.mag  = mag;
        setup_next.rem  = lpi_pkg::DOTW'(num_sh[lpi_pkg::NW-1:lpi_pkg::QB]);
        setup_next.num  = num_sh;
        setup_next.quo  = '0;
        setup_next.ln   = ln2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_reg.vld <= 1'b0;
        end
        else if (en)
        begin
            setup_reg <= setup_next;
        end
    end

    assign setup = setup_reg;

endmodule

@@ rtl/lpi_div.sv @@
// Pipelined restoring divider: one quotient bit per stage.
module lpi_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  lpi_pkg::div_t din,
    output lpi_pkg::div_t dout
);

    lpi_pkg::div_t st [lpi_pkg::QB+1];

    assign st[0] = din;

    for (genvar k = 0; k < lpi_pkg::QB; k++)
    begin : g_stage
        lpi_pkg::div_t          stage_reg;
        lpi_pkg::div_t          stage_next;
        logic [lpi_pkg::DOTW:0] trial;
        logic                   ge;

        always_comb
        begin
            trial      = {st[k].rem, st[k].num[lpi_pkg::QB-1-k]};
            ge         = trial >= {1'b0, st[k].mag};
            stage_next = st[k];
            stage_next.rem = ge ? lpi_pkg::DOTW'(trial - {1'b0, st[k].mag})
                                : lpi_pkg::DOTW'(trial);
            stage_next.quo[lpi_pkg::QB-1-k] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg.vld <= 1'b0;
            end
            else if (en)
            begin
                stage_reg <= stage_next;
            end
        end

        assign st[k+1] = stage_reg;
    end

    assign dout = st[lpi_pkg::QB];

endmodule

@@ rtl/lpi_coord.sv @@
// Quotient limit, split products, point sums and clamping: four stages.
module lpi_coord (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  lpi_pkg::div_t          q,
    output logic                   out_vld,
    output logic                   out_hit,
    output lpi_pkg::vec_t          out_pt,
    output logic                   out_sat
);

    logic                              a_vld_reg;
    logic                              a_para_reg;
    logic signed [lpi_pkg::TW-1:0]     t_reg;
    logic signed [lpi_pkg::TW-1:0]     t_next;
    logic [lpi_pkg::QB-1:0]            tmag;
    lpi_pkg::line_t                    a_ln_reg;

    logic                              b_vld_reg;
    logic                              b_para_reg;
    logic signed [lpi_pkg::PPW-1:0]    pplo_reg [3];
    logic signed [lpi_pkg::PPW-1:0]    pphi_reg [3];
    logic signed [lpi_pkg::PPW-1:0]    pplo_next [3];
    logic signed [lpi_pkg::PPW-1:0]    pphi_next [3];
    lpi_pkg::vec_t                     b_p_reg;

    logic                              c_vld_reg;
    logic                              c_para_reg;
    logic signed [lpi_pkg::PRODW-1:0]  prod_reg [3];
    logic signed [lpi_pkg::PRODW-1:0]  prod_next [3];
    lpi_pkg::vec_t                     c_p_reg;

    logic                              vld_reg;
    logic                              hit_reg;
    logic                              sat_reg;
    lpi_pkg::vec_t                     pt_reg;
    logic                              hit_next;
    logic                              sat_next;
    lpi_pkg::vec_t                     pt_next;
    logic signed [lpi_pkg::RW-1:0]     r [3];
    logic [2:0]                        sat_hi;
    logic [2:0]                        sat_lo;

    always_comb
    begin
        tmag   = (q.ovf || (q.quo > lpi_pkg::TLIM)) ? lpi_pkg::TLIM : q.quo;
        t_next = q.neg ? -$signed(lpi_pkg::TW'(tmag)) : $signed(lpi_pkg::TW'(tmag));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= q.vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            vld_reg   <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_para_reg <= q.para;
            t_reg      <= t_next;
            a_ln_reg   <= q.ln;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pplo_next[i] = $signed(a_ln_reg.v[i])
                         * $signed({1'b0, t_reg[lpi_pkg::LOB-1:0]});
            pphi_next[i] = $signed(a_ln_reg.v[i])
                         * $signed(t_reg[lpi_pkg::TW-1:lpi_pkg::LOB]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_para_reg <= a_para_reg;
            pplo_reg   <= pplo_next;
            pphi_reg   <= pphi_next;
            b_p_reg    <= a_ln_reg.p;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = (lpi_pkg::PRODW'(pphi_reg[i]) <<< lpi_pkg::LOB)
                         + lpi_pkg::PRODW'(pplo_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_para_reg <= b_para_reg;
            prod_reg   <= prod_next;
            c_p_reg    <= b_p_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r[i] = lpi_pkg::RW'($signed(c_p_reg[i]))
                 + lpi_pkg::RW'(prod_reg[i] >>> lpi_pkg::FRAC_BITS);
            sat_hi[i] = !r[i][lpi_pkg::RW-1] && (|r[i][lpi_pkg::RW-2:lpi_pkg::CW-1]);
            sat_lo[i] = r[i][lpi_pkg::RW-1] && !(&r[i][lpi_pkg::RW-2:lpi_pkg::CW-1]);
            if (c_para_reg)
            begin
                pt_next[i] = '0;
            end
            else if (sat_hi[i])
            begin
                pt_next[i] = {1'b0, {(lpi_pkg::CW-1){1'b1}}};
            end
            else if (sat_lo[i])
            begin
                pt_next[i] = {1'b1, {(lpi_pkg::CW-1){1'b0}}};
            end
            else
            begin
                pt_next[i] = r[i][lpi_pkg::CW-1:0];
            end
        end
        hit_next = !c_para_reg;
        sat_next = !c_para_reg && ((|sat_hi) || (|sat_lo));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
            sat_reg <= sat_next;
            pt_reg  <= pt_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_hit = hit_reg;
    assign out_sat = sat_reg;
    assign out_pt  = pt_reg;

endmodule

@@ rtl/line_plane_intersection_top.sv @@
// Line/plane intersection top level: APB threshold register and pipeline.
// Pipeline: 3 dot/setup stages, 50 divider stages, 4 product/clamp stages.
// Throughput: one request per cycle while no response waits untaken.
// The whole pipeline holds while a response waits and is not taken.
// Reset: asynchronous, active low; clears all valid bits and sets the
// parallel threshold to 1.
module line_plane_intersection_top (
    input  logic                      clk,
    input  logic                      rst_n,
    lpi_req_if.sink                   req,
    lpi_rsp_if.source                 rsp,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [lpi_pkg::AW-1:0]    paddr,
    input  logic [lpi_pkg::DW-1:0]    pwdata,
    output logic [lpi_pkg::DW-1:0]    prdata,
    output logic                      pready
);

    logic                        en;
    logic [lpi_pkg::THRW-1:0]    thr_reg;
    logic [lpi_pkg::THRW-1:0]    thr_next;
    lpi_pkg::vec_t               n;
    lpi_pkg::line_t              ln;
    lpi_pkg::div_t               setup;
    lpi_pkg::div_t               quot;
    lpi_pkg::vec_t               pt;

    assign pready = 1'b1;

    always_comb
    begin
        thr_next = thr_reg;
        if (psel && penable && pwrite && (paddr[2] == lpi_pkg::REG_THRESHOLD))
        begin
            thr_next = pwdata[lpi_pkg::THRW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= lpi_pkg::THRESHOLD_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign prdata = (paddr[2] == lpi_pkg::REG_THRESHOLD)
                  ? lpi_pkg::DW'(thr_reg) : '0;

    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    assign n[0]    = req.plane_normal_x[lpi_pkg::CW-1:0];
    assign n[1]    = req.plane_normal_y[lpi_pkg::CW-1:0];
    assign n[2]    = req.plane_normal_z[lpi_pkg::CW-1:0];
    assign ln.p[0] = req.point_x[lpi_pkg::CW-1:0];
    assign ln.p[1] = req.point_y[lpi_pkg::CW-1:0];
    assign ln.p[2] = req.point_z[lpi_pkg::CW-1:0];
    assign ln.v[0] = req.dir_x[lpi_pkg::CW-1:0];
    assign ln.v[1] = req.dir_y[lpi_pkg::CW-1:0];
    assign ln.v[2] = req.dir_z[lpi_pkg::CW-1:0];

    lpi_dot u_dot (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (req.valid),
        .n      (n),
        .d      (req.plane_offset[lpi_pkg::CW-1:0]),
        .ln     (ln),
        .thr    (thr_reg),
        .setup  (setup)
    );

    lpi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (setup),
        .dout  (quot)
    );

    lpi_coord u_coord (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .q       (quot),
        .out_vld (rsp.valid),
        .out_hit (rsp.hit),
        .out_pt  (pt),
        .out_sat (rsp.saturated)
    );

    assign rsp.hit_x = pt[0];
    assign rsp.hit_y = pt[1];
    assign rsp.hit_z = pt[2];

endmodule
